@@ rtl/belt_pkg.sv @@
// BelT cipher package: H substitution table, G functions, key and block types.
// Used by belt_round and belt_block_cipher_top.
`timescale 1ns / 1ps
`default_nettype none
package belt_pkg;

	localparam int NumRounds = 8;

	typedef enum logic [1:0] {
		KEY_128 = 2'd0,
		KEY_192 = 2'd1,
		KEY_256 = 2'd2,
		KEY_RSV = 2'd3
	} key_size_t;

	typedef enum logic [2:0] {
		REG_KEY01  = 3'd0,
		REG_KEY23  = 3'd1,
		REG_KEY45  = 3'd2,
		REG_KEY67  = 3'd3,
		REG_KSIZE  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        dec;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} blk_t;

	function automatic logic [7:0] hbox(input logic [7:0] x);
		logic [7:0] h;
		case (x)
			8'h00: h = 8'hb1; 8'h01: h = 8'h94; 8'h02: h = 8'hba; 8'h03: h = 8'hc8;
			8'h04: h = 8'h0a; 8'h05: h = 8'h08; 8'h06: h = 8'hf5; 8'h07: h = 8'h3b;
			8'h08: h = 8'h36; 8'h09: h = 8'h6d; 8'h0a: h = 8'h00; 8'h0b: h = 8'h8e;
			8'h0c: h = 8'h58; 8'h0d: h = 8'h4a; 8'h0e: h = 8'h5d; 8'h0f: h = 8'he4;
			8'h10: h = 8'h85; 8'h11: h = 8'h04; 8'h12: h = 8'hfa; 8'h13: h = 8'h9d;
			8'h14: h = 8'h1b; 8'h15: h = 8'hb6; 8'h16: h = 8'hc7; 8'h17: h = 8'hac;
			8'h18: h = 8'h25; 8'h19: h = 8'h2e; 8'h1a: h = 8'h72; 8'h1b: h = 8'hc2;
			8'h1c: h = 8'h02; 8'h1d: h = 8'hfd; 8'h1e: h = 8'hce; 8'h1f: h = 8'h0d;
			8'h20: h = 8'h5b; 8'h21: h = 8'he3; 8'h22: h = 8'hd6; 8'h23: h = 8'h12;
			8'h24: h = 8'h17; 8'h25: h = 8'hb9; 8'h26: h = 8'h61; 8'h27: h = 8'h81;
			8'h28: h = 8'hfe; 8'h29: h = 8'h67; 8'h2a: h = 8'h86; 8'h2b: h = 8'had;
			8'h2c: h = 8'h71; 8'h2d: h = 8'h6b; 8'h2e: h = 8'h89; 8'h2f: h = 8'h0b;
			8'h30: h = 8'h5c; 8'h31: h = 8'hb0; 8'h32: h = 8'hc0; 8'h33: h = 8'hff;
			8'h34: h = 8'h33; 8'h35: h = 8'hc3; 8'h36: h = 8'h56; 8'h37: h = 8'hb8;
			8'h38: h = 8'h35; 8'h39: h = 8'hc4; 8'h3a: h = 8'h05; 8'h3b: h = 8'hae;
			8'h3c: h = 8'hd8; 8'h3d: h = 8'he0; 8'h3e: h = 8'h7f; 8'h3f: h = 8'h99;
			8'h40: h = 8'he1; 8'h41: h = 8'h2b; 8'h42: h = 8'hdc; 8'h43: h = 8'h1a;
			8'h44: h = 8'he2; 8'h45: h = 8'h82; 8'h46: h = 8'h57; 8'h47: h = 8'hec;
			8'h48: h = 8'h70; 8'h49: h = 8'h3f; 8'h4a: h = 8'hcc; 8'h4b: h = 8'hf0;
			8'h4c: h = 8'h95; 8'h4d: h = 8'hee; 8'h4e: h = 8'h8d; 8'h4f: h = 8'hf1;
			8'h50: h = 8'hc1; 8'h51: h = 8'hab; 8'h52: h = 8'h76; 8'h53: h = 8'h38;
			8'h54: h = 8'h9f; 8'h55: h = 8'he6; 8'h56: h = 8'h78; 8'h57: h = 8'hca;
			8'h58: h = 8'hf7; 8'h59: h = 8'hc6; 8'h5a: h = 8'hf8; 8'h5b: h = 8'h60;
			8'h5c: h = 8'hd5; 8'h5d: h = 8'hbb; 8'h5e: h = 8'h9c; 8'h5f: h = 8'h4f;
			8'h60: h = 8'hf3; 8'h61: h = 8'h3c; 8'h62: h = 8'h65; 8'h63: h = 8'h7b;
			8'h64: h = 8'h63; 8'h65: h = 8'h7c; 8'h66: h = 8'h30; 8'h67: h = 8'h6a;
			8'h68: h = 8'hdd; 8'h69: h = 8'h4e; 8'h6a: h = 8'ha7; 8'h6b: h = 8'h79;
			8'h6c: h = 8'h9e; 8'h6d: h = 8'hb2; 8'h6e: h = 8'h3d; 8'h6f: h = 8'h31;
			8'h70: h = 8'h3e; 8'h71: h = 8'h98; 8'h72: h = 8'hb5; 8'h73: h = 8'h6e;
			8'h74: h = 8'h27; 8'h75: h = 8'hd3; 8'h76: h = 8'hbc; 8'h77: h = 8'hcf;
			8'h78: h = 8'h59; 8'h79: h = 8'h1e; 8'h7a: h = 8'h18; 8'h7b: h = 8'h1f;
			8'h7c: h = 8'h4c; 8'h7d: h = 8'h5a; 8'h7e: h = 8'hb7; 8'h7f: h = 8'h93;
			8'h80: h = 8'he9; 8'h81: h = 8'hde; 8'h82: h = 8'he7; 8'h83: h = 8'h2c;
			8'h84: h = 8'h8f; 8'h85: h = 8'h0c; 8'h86: h = 8'h0f; 8'h87: h = 8'ha6;
			8'h88: h = 8'h2d; 8'h89: h = 8'hdb; 8'h8a: h = 8'h49; 8'h8b: h = 8'hf4;
			8'h8c: h = 8'h6f; 8'h8d: h = 8'h73; 8'h8e: h = 8'h96; 8'h8f: h = 8'h47;
			8'h90: h = 8'h06; 8'h91: h = 8'h07; 8'h92: h = 8'h53; 8'h93: h = 8'h16;
			8'h94: h = 8'hed; 8'h95: h = 8'h24; 8'h96: h = 8'h7a; 8'h97: h = 8'h37;
			8'h98: h = 8'h39; 8'h99: h = 8'hcb; 8'h9a: h = 8'ha3; 8'h9b: h = 8'h83;
			8'h9c: h = 8'h03; 8'h9d: h = 8'ha9; 8'h9e: h = 8'h8b; 8'h9f: h = 8'hf6;
			8'ha0: h = 8'h92; 8'ha1: h = 8'hbd; 8'ha2: h = 8'h9b; 8'ha3: h = 8'h1c;
			8'ha4: h = 8'he5; 8'ha5: h = 8'hd1; 8'ha6: h = 8'h41; 8'ha7: h = 8'h01;
			8'ha8: h = 8'h54; 8'ha9: h = 8'h45; 8'haa: h = 8'hfb; 8'hab: h = 8'hc9;
			8'hac: h = 8'h5e; 8'had: h = 8'h4d; 8'hae: h = 8'h0e; 8'haf: h = 8'hf2;
			8'hb0: h = 8'h68; 8'hb1: h = 8'h20; 8'hb2: h = 8'h80; 8'hb3: h = 8'haa;
			8'hb4: h = 8'h22; 8'hb5: h = 8'h7d; 8'hb6: h = 8'h64; 8'hb7: h = 8'h2f;
			8'hb8: h = 8'h26; 8'hb9: h = 8'h87; 8'hba: h = 8'hf9; 8'hbb: h = 8'h34;
			8'hbc: h = 8'h90; 8'hbd: h = 8'h40; 8'hbe: h = 8'h55; 8'hbf: h = 8'h11;
			8'hc0: h = 8'hbe; 8'hc1: h = 8'h32; 8'hc2: h = 8'h97; 8'hc3: h = 8'h13;
			8'hc4: h = 8'h43; 8'hc5: h = 8'hfc; 8'hc6: h = 8'h9a; 8'hc7: h = 8'h48;
			8'hc8: h = 8'ha0; 8'hc9: h = 8'h2a; 8'hca: h = 8'h88; 8'hcb: h = 8'h5f;
			8'hcc: h = 8'h19; 8'hcd: h = 8'h4b; 8'hce: h = 8'h09; 8'hcf: h = 8'ha1;
			8'hd0: h = 8'h7e; 8'hd1: h = 8'hcd; 8'hd2: h = 8'ha4; 8'hd3: h = 8'hd0;
			8'hd4: h = 8'h15; 8'hd5: h = 8'h44; 8'hd6: h = 8'haf; 8'hd7: h = 8'h8c;
			8'hd8: h = 8'ha5; 8'hd9: h = 8'h84; 8'hda: h = 8'h50; 8'hdb: h = 8'hbf;
			8'hdc: h = 8'h66; 8'hdd: h = 8'hd2; 8'hde: h = 8'he8; 8'hdf: h = 8'h8a;
			8'he0: h = 8'ha2; 8'he1: h = 8'hd7; 8'he2: h = 8'h46; 8'he3: h = 8'h52;
			8'he4: h = 8'h42; 8'he5: h = 8'ha8; 8'he6: h = 8'hdf; 8'he7: h = 8'hb3;
			8'he8: h = 8'h69; 8'he9: h = 8'h74; 8'hea: h = 8'hc5; 8'heb: h = 8'h51;
			8'hec: h = 8'heb; 8'hed: h = 8'h23; 8'hee: h = 8'h29; 8'hef: h = 8'h21;
			8'hf0: h = 8'hd4; 8'hf1: h = 8'hef; 8'hf2: h = 8'hd9; 8'hf3: h = 8'hb4;
			8'hf4: h = 8'h3a; 8'hf5: h = 8'h62; 8'hf6: h = 8'h28; 8'hf7: h = 8'h75;
			8'hf8: h = 8'h91; 8'hf9: h = 8'h14; 8'hfa: h = 8'h10; 8'hfb: h = 8'hea;
			8'hfc: h = 8'h77; 8'hfd: h = 8'h6c; 8'hfe: h = 8'hda; default: h = 8'h1d;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] gsub(input logic [31:0] u);
		return {hbox(u[31:24]), hbox(u[23:16]), hbox(u[15:8]), hbox(u[7:0])};
	endfunction

	function automatic logic [31:0] g5(input logic [31:0] u);
		logic [31:0] s;
		s = gsub(u);
		return {s[26:0], s[31:27]};
	endfunction

	function automatic logic [31:0] g13(input logic [31:0] u);
		logic [31:0] s;
		s = gsub(u);
		return {s[18:0], s[31:19]};
	endfunction

	function automatic logic [31:0] g21(input logic [31:0] u);
		logic [31:0] s;
		s = gsub(u);
		return {s[10:0], s[31:11]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/belt_round.sv @@
// One BelT round as a three-stage pipeline slice with stall hold.
// Depends on belt_pkg for the G functions and the block type.
`timescale 1ns / 1ps
`default_nettype none
module belt_round
	import belt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        in_vld,
	input  wire blk_t        in_blk,
	input  wire logic [2:0]  enc_rnd,
	input  wire logic [255:0] key,
	output logic             out_vld,
	output blk_t             out_blk
);

	localparam logic [2:0] LastRnd = 3'(NumRounds - 1);

	logic [2:0]  rnd;
	logic [5:0]  base;
	logic [31:0] q [7];
	logic [31:0] kw [8];

	logic        vld_s1, vld_s2;
	blk_t        blk_s1, blk_s2;
	logic [2:0]  rnd_s1;
	logic [3:0]  rnd_s1_n;
	logic [31:0] q3_s1, q4_s1, q5_s1, q6_s1;
	logic [31:0] q4_s2, q5_s2, q6_s2;
	logic [31:0] e_s2;

	blk_t        x1, x2, x3;
	logic [31:0] e1;

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			kw[n] = key[32*n +: 32];
		end
		rnd  = in_blk.dec ? (LastRnd - enc_rnd) : enc_rnd;
		base = 6'(7 * rnd);
		for (int j = 0; j < 7; j++) begin
			q[j] = in_blk.dec ? kw[3'(base + 6'(6 - j))] : kw[3'(base + 6'(j))];
		end
	end

	always_comb begin
		x1   = in_blk;
		x1.b = x1.b ^ g5(x1.a + q[0]);
		x1.c = x1.c ^ g21(x1.d + q[1]);
		x1.a = x1.a - g13(x1.b + q[2]);
	end

	assign rnd_s1_n = {1'b0, rnd_s1} + 4'd1;

	always_comb begin
		e1 = g21(blk_s1.b + blk_s1.c + q3_s1) ^ {28'd0, rnd_s1_n};
	end

	always_comb begin
		x2   = blk_s2;
		x2.b = x2.b + e_s2;
		x2.c = x2.c - e_s2;
		x2.d = x2.d + g13(x2.c + q4_s2);
		x2.b = x2.b ^ g21(x2.a + q5_s2);
		x2.c = x2.c ^ g5(x2.d + q6_s2);
		x3     = x2;
		if (x2.dec) begin
			x3.a = x2.c;
			x3.b = x2.a;
			x3.c = x2.d;
			x3.d = x2.b;
		end else begin
			x3.a = x2.b;
			x3.b = x2.d;
			x3.c = x2.a;
			x3.d = x2.c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s1  <= x1;
			rnd_s1  <= rnd;
			q3_s1   <= q[3];
			q4_s1   <= q[4];
			q5_s1   <= q[5];
			q6_s1   <= q[6];
			blk_s2  <= blk_s1;
			e_s2    <= e1;
			q4_s2   <= q4_s1;
			q5_s2   <= q5_s1;
			q6_s2   <= q6_s1;
			out_blk <= x3;
		end
	end

endmodule
`default_nettype wire

@@ rtl/belt_block_cipher_top.sv @@
// BelT block cipher top level: key registers, expansion, eight round slices.
// Depends on belt_pkg and belt_round.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Input channel in_valid/in_ready carries mode and block_word_0..3; the
//  output channel out_valid/out_ready carries result_word_0..3. One block
//  in gives one block out, in order.
//  Config channel cfg_valid/cfg_ready writes register cfg_index with
//  cfg_data (0..3 key word pairs, 4 key size); write only while idle.
//  The pipeline is eight round slices of three register stages each.
//  Throughput is one block per cycle unless stalled; the pipeline moves as one.
//  A stalled receiver freezes every stage; in_ready follows out_ready or an
//  empty output stage, so nothing is lost or repeated.
//  Reset clears all valid bits, the key words to zero and key size to 256.
module belt_block_cipher_top
	import belt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [31:0] block_word_0,
	input  wire logic [31:0] block_word_1,
	input  wire logic [31:0] block_word_2,
	input  wire logic [31:0] block_word_3,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result_word_0,
	output logic [31:0]      result_word_1,
	output logic [31:0]      result_word_2,
	output logic [31:0]      result_word_3,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [63:0]  key01_q, key23_q, key45_q, key67_q;
	key_size_t    ksize_q;
	logic [255:0] key;
	logic [31:0]  k0, k1, k2, k3, k4, k5;
	logic         adv;
	logic         vld [NumRounds+1];
	blk_t         blk [NumRounds+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q <= '0;
			key23_q <= '0;
			key45_q <= '0;
			key67_q <= '0;
			ksize_q <= KEY_256;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_KEY01: key01_q <= cfg_data;
				REG_KEY23: key23_q <= cfg_data;
				REG_KEY45: key45_q <= cfg_data;
				REG_KEY67: key67_q <= cfg_data;
				REG_KSIZE: ksize_q <= key_size_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		k0 = key01_q[31:0];
		k1 = key01_q[63:32];
		k2 = key23_q[31:0];
		k3 = key23_q[63:32];
		k4 = key45_q[31:0];
		k5 = key45_q[63:32];
		case (ksize_q)
			KEY_128: key = {key23_q, key01_q, key23_q, key01_q};
			KEY_192: key = {k3 ^ k4 ^ k5, k0 ^ k1 ^ k2, key45_q, key23_q, key01_q};
			default: key = {key67_q, key45_q, key23_q, key01_q};
		endcase
	end

	assign adv      = out_ready || !out_valid;
	assign in_ready = adv;

	assign vld[0] = in_valid;
	assign blk[0] = '{dec: mode, a: block_word_0, b: block_word_1,
		c: block_word_2, d: block_word_3};

	for (genvar r = 0; r < NumRounds; r++) begin : g_rnd
		belt_round u_rnd (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_vld  (vld[r]),
			.in_blk  (blk[r]),
			.enc_rnd (3'(r)),
			.key     (key),
			.out_vld (vld[r+1]),
			.out_blk (blk[r+1])
		);
	end

	assign out_valid     = vld[NumRounds];
	assign result_word_0 = blk[NumRounds].dec ? blk[NumRounds].c : blk[NumRounds].b;
	assign result_word_1 = blk[NumRounds].dec ? blk[NumRounds].a : blk[NumRounds].d;
	assign result_word_2 = blk[NumRounds].dec ? blk[NumRounds].d : blk[NumRounds].a;
	assign result_word_3 = blk[NumRounds].dec ? blk[NumRounds].b : blk[NumRounds].c;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_word_0))
		else $error("result word changed under stall");
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline blocked with empty output");
	a_cfg_key: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_KSIZE |=> ksize_q == key_size_t'($past(cfg_data[1:0])))
		else $error("key size write lost");
`endif

endmodule
`default_nettype wire
